// ===== rtl/cle_pkg.sv =====
// cle_pkg: shared types, character codes and controller/datapath interface
// for the console line editor. No dependencies.
`timescale 1ns / 1ps

package cle_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_EOT = 8'h04;  // Ctrl-D
    localparam logic [7:0] CH_BS  = 8'h08;  // Ctrl-H
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DLE = 8'h10;  // Ctrl-P
    localparam logic [7:0] CH_NAK = 8'h15;  // Ctrl-U
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Operation codes
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Read status codes
    localparam logic [1:0] RS_BYTE     = 2'd0;
    localparam logic [1:0] RS_EOF      = 2'd1;
    localparam logic [1:0] RS_EMPTY    = 2'd2;
    localparam logic [1:0] RS_NOT_READ = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_char;
        logic       first_in_request;
    } item_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_committed;
        logic [1:0] read_status;
        logic [7:0] read_byte;
        logic       ends_line;
    } result_t;

    typedef enum logic [1:0] {
        CC_NONE,
        CC_KILL,
        CC_ERASE,
        CC_STORE
    } char_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_KILL,
        ST_READ,
        ST_RESP
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic store;
        logic erase_one;
        logic kill_begin;
        logic kill_step;
        logic read_begin;
        logic read_finish;
        logic read_empty;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic        is_read;
        char_class_t cls;
        logic        room;
        logic        edit_at_comm;
        logic        probe_at_comm;
        logic        rdata_lf;
        logic        buf_empty;
    } dp_status_t;

    function automatic char_class_t classify(input logic [7:0] c);
        unique case (c) inside
            CH_NUL, CH_DLE: return CC_NONE;
            CH_NAK:         return CC_KILL;
            CH_BS, CH_DEL:  return CC_ERASE;
            default:        return CC_STORE;
        endcase
    endfunction

endpackage

// ===== rtl/cle_ctrl.sv =====
// cle_ctrl: sequencing state machine for the console line editor.
// Depends on cle_pkg; drives cle_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module cle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  cle_pkg::dp_status_t status,
    output cle_pkg::dp_cmd_t    cmd
);

    cle_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cle_pkg::ST_EXEC;
                end
            end
            cle_pkg::ST_EXEC:
            begin
                state_next = cle_pkg::ST_RESP;
                if (status.is_read)
                begin
                    if (!status.buf_empty)
                    begin
                        state_next = cle_pkg::ST_READ;
                    end
                end
                else if (status.cls == cle_pkg::CC_KILL && !status.edit_at_comm)
                begin
                    state_next = cle_pkg::ST_KILL;
                end
            end
            cle_pkg::ST_KILL:
            begin
                if (status.rdata_lf || status.probe_at_comm)
                begin
                    state_next = cle_pkg::ST_RESP;
                end
            end
            cle_pkg::ST_READ:
            begin
                state_next = cle_pkg::ST_RESP;
            end
            cle_pkg::ST_RESP:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != cle_pkg::ST_IDLE);
        done = 1'b0;
        unique case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                cmd.capture = start;
            end
            cle_pkg::ST_EXEC:
            begin
                if (status.is_read)
                begin
                    cmd.read_empty = status.buf_empty;
                    cmd.read_begin = !status.buf_empty;
                end
                else
                begin
                    case (status.cls)
                        cle_pkg::CC_STORE: cmd.store      = status.room;
                        cle_pkg::CC_ERASE: cmd.erase_one  = !status.edit_at_comm;
                        cle_pkg::CC_KILL:  cmd.kill_begin = !status.edit_at_comm;
                        default:           cmd = '0;
                    endcase
                end
            end
            cle_pkg::ST_KILL:
            begin
                cmd.kill_step = !status.rdata_lf;
            end
            cle_pkg::ST_READ:
            begin
                cmd.read_finish = 1'b1;
            end
            cle_pkg::ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not enter execution");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done strobe longer than one cycle");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

// ===== rtl/cle_datapath.sv =====
// cle_datapath: line store memory, ring indices and result register of the
// console line editor. Depends on cle_pkg; commanded by cle_ctrl.
`timescale 1ns / 1ps

module cle_datapath #(
    parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cle_pkg::item_t      request,
    input  cle_pkg::dp_cmd_t    cmd,
    output cle_pkg::dp_status_t status,
    output cle_pkg::result_t    result
);

    localparam int SPAN = 2 * BUFFER_DEPTH;
    localparam int IW   = $clog2(SPAN);
    localparam int AW   = $clog2(BUFFER_DEPTH);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == IW'(SPAN - 1)) ? '0 : i + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? IW'(SPAN - 1) : i - IW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_addr(input logic [IW-1:0] i);
        return (i >= IW'(BUFFER_DEPTH)) ? AW'(i - IW'(BUFFER_DEPTH)) : AW'(i);
    endfunction

    function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] t;
        t = (a >= b) ? ({1'b0, a} - {1'b0, b})
                     : ({1'b0, a} + (IW+1)'(SPAN) - {1'b0, b});
        return IW'(t);
    endfunction

    logic [7:0]       line_store [BUFFER_DEPTH];
    logic [7:0]       rdata_reg;
    logic [IW-1:0]    read_idx_reg, comm_idx_reg, edit_idx_reg, probe_idx_reg;
    logic [IW-1:0]    read_idx_next, comm_idx_next, edit_idx_next, probe_idx_next;
    cle_pkg::item_t   req_reg, req_next;
    cle_pkg::result_t res_reg, res_next;

    logic [7:0]       store_char;
    logic [IW-1:0]    edit_inc;
    logic [AW-1:0]    raddr;

    assign store_char = (req_reg.rx_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF
                                                             : req_reg.rx_char;
    assign edit_inc   = idx_inc(edit_idx_reg);

    always_comb
    begin
        if (cmd.kill_begin)
        begin
            raddr = idx_addr(idx_dec(edit_idx_reg));
        end
        else if (cmd.kill_step)
        begin
            raddr = idx_addr(idx_dec(probe_idx_reg));
        end
        else
        begin
            raddr = idx_addr(read_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            line_store[idx_addr(edit_idx_reg)] <= store_char;
        end
        rdata_reg <= line_store[raddr];
    end

    always_comb
    begin
        read_idx_next  = read_idx_reg;
        comm_idx_next  = comm_idx_reg;
        edit_idx_next  = edit_idx_reg;
        probe_idx_next = probe_idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;

        if (cmd.capture)
        begin
            req_next             = request;
            res_next             = '0;
            res_next.read_status = cle_pkg::RS_NOT_READ;
        end
        if (cmd.store)
        begin
            edit_idx_next       = edit_inc;
            res_next.echo_valid = 1'b1;
            res_next.echo_char  = store_char;
            if (store_char == cle_pkg::CH_LF || store_char == cle_pkg::CH_EOT ||
                idx_diff(edit_inc, read_idx_reg) == IW'(BUFFER_DEPTH))
            begin
                comm_idx_next           = edit_inc;
                res_next.line_committed = 1'b1;
            end
        end
        if (cmd.erase_one)
        begin
            edit_idx_next        = idx_dec(edit_idx_reg);
            res_next.erase_count = 8'd1;
        end
        if (cmd.kill_begin)
        begin
            probe_idx_next = idx_dec(edit_idx_reg);
        end
        if (cmd.kill_step)
        begin
            // rdata_reg holds the entry at probe and is not a newline
            edit_idx_next        = probe_idx_reg;
            probe_idx_next       = idx_dec(probe_idx_reg);
            res_next.erase_count = res_reg.erase_count + 8'd1;
        end
        if (cmd.read_empty)
        begin
            res_next.read_status = cle_pkg::RS_EMPTY;
        end
        if (cmd.read_finish)
        begin
            if (rdata_reg == cle_pkg::CH_EOT)
            begin
                res_next.read_status = cle_pkg::RS_EOF;
                if (req_reg.first_in_request)
                begin
                    read_idx_next = idx_inc(read_idx_reg);
                end
            end
            else
            begin
                read_idx_next        = idx_inc(read_idx_reg);
                res_next.read_status = cle_pkg::RS_BYTE;
                res_next.read_byte   = rdata_reg;
                res_next.ends_line   = (rdata_reg == cle_pkg::CH_LF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_idx_reg <= '0;
            comm_idx_reg <= '0;
            edit_idx_reg <= '0;
        end
        else
        begin
            read_idx_reg <= read_idx_next;
            comm_idx_reg <= comm_idx_next;
            edit_idx_reg <= edit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_idx_reg <= probe_idx_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
    end

    assign status.is_read       = (req_reg.op == cle_pkg::OP_READ);
    assign status.cls           = cle_pkg::classify(req_reg.rx_char);
    assign status.room          = idx_diff(edit_idx_reg, read_idx_reg) < IW'(BUFFER_DEPTH);
    assign status.edit_at_comm  = (edit_idx_reg == comm_idx_reg);
    assign status.probe_at_comm = (probe_idx_reg == comm_idx_reg);
    assign status.rdata_lf      = (rdata_reg == cle_pkg::CH_LF);
    assign status.buf_empty     = (read_idx_reg == comm_idx_reg);

    assign result = res_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_diff(edit_idx_reg, read_idx_reg) <= IW'(BUFFER_DEPTH))
        else $error("edit index ran more than one buffer ahead of read index");

    a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
        idx_diff(comm_idx_reg, read_idx_reg) <= idx_diff(edit_idx_reg, read_idx_reg))
        else $error("committed index outside read..edit window");

    a_kill_no_lf: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kill_step |-> (rdata_reg != cle_pkg::CH_LF && !status.edit_at_comm))
        else $error("kill step erased a newline or past the committed point");

endmodule

// ===== rtl/console_line_editor_unit.sv =====
// console_line_editor_unit: top level of the console line editor.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
`timescale 1ns / 1ps

// Canonical terminal line editor over a ring buffer of BUFFER_DEPTH bytes.
// A transaction is accepted on a rising edge with start high and busy low;
// the request carries either a received keyboard character (op 0) or a
// one-byte read request (op 1). Exactly one result comes back per
// transaction: done is high for one cycle and result is valid in that cycle
// only. The receiver cannot stall, so capture result whenever done is seen.
// From accept, a keyboard character that is stored, ignored or erases one
// position, and a read of an empty buffer, go from EXEC straight to RESP;
// a read that finds a byte passes through READ (one registered memory read).
// A Ctrl-U kill walks back through the line one stored entry per cycle on
// the single memory read port, in the KILL state, before RESP.
// busy drops the cycle after done, so a transaction is taken only after the
// last one ends. The line store has no reset; reads only reach entries that
// were written. The read, committed and edit index registers reset to zero.

module console_line_editor_unit #(
    parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cle_pkg::item_t   request,
    output logic             done,
    output cle_pkg::result_t result
);

    cle_pkg::dp_cmd_t    cmd;
    cle_pkg::dp_status_t status;

    // Controller: sequences capture, execute, kill walk, read and response.
    cle_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath: line store, read/committed/edit indices, result register.
    cle_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule
